// ===== hw/rtl/ifdl_pkg.sv =====
// ----------------------------------------------------------------------------
// ifdl_pkg
// Shared constants for the interpolated fractional delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package ifdl_pkg;

    // Default geometry
    localparam int DEPTH_DEF       = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fraction width of the delay request and of the read position
    localparam int FRAC_BITS = 24;

    // Width of the line_length register field
    localparam int CFG_LEN_BITS = 13;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;

    // Requests that can be held at once: front stage, queue, back, final stage,
    // output register
    localparam int MAX_INFLIGHT = 6;

endpackage

`default_nettype wire

// ===== hw/rtl/ifdl_queue.sv =====
// ----------------------------------------------------------------------------
// ifdl_queue
// Small FIFO that decouples the address front from the memory back.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdl_queue #(
    parameter int WIDTH   = 8,
    parameter int DEPTH_Q = ifdl_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import ifdl_pkg::*;

    localparam int PTR_W = (DEPTH_Q > 1) ? $clog2(DEPTH_Q) : 1;
    localparam int CNT_W = $clog2(DEPTH_Q + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH_Q];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH_Q));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH_Q - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH_Q - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ifdl_front.sv =====
// ----------------------------------------------------------------------------
// ifdl_front
// Accepts requests, tracks the write pointer and works out the two ring
// indexes and the interpolation fraction for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdl_front #(
    parameter int DEPTH       = ifdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = ifdl_pkg::SAMPLE_BITS_DEF,
    localparam int ADDR_W     = $clog2(DEPTH),
    localparam int LEN_W      = ADDR_W + 1,
    localparam int CMD_W      = SAMPLE_BITS + 3 * ADDR_W + ifdl_pkg::FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [LEN_W-1:0]              line_len,
    input  wire logic                          restart,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic [ifdl_pkg::FRAC_BITS-1:0] s_delay_fraction,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output logic [CMD_W-1:0]                   cmd_data
);
    import ifdl_pkg::*;

    localparam int PROD_W = FRAC_BITS + LEN_W;
    localparam int POS_W  = PROD_W + 1;

    // Same layout as the back's command
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [ADDR_W-1:0]      wr_addr;
        logic [ADDR_W-1:0]      idx1;
        logic [ADDR_W-1:0]      idx2;
        logic [FRAC_BITS-1:0]   frac;
    } cmd_t;

    logic                   a_valid_reg;
    logic [PROD_W-1:0]      a_prod_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic [ADDR_W-1:0]      a_wp_reg;
    logic [ADDR_W-1:0]      wp_reg;
    logic [ADDR_W-1:0]      wp_next;
    logic [LEN_W-1:0]       wp_plus;
    logic                   accept;
    logic                   push;
    logic signed [POS_W-1:0] pos_direct;
    logic signed [POS_W-1:0] pos_wrapped;
    logic signed [POS_W-1:0] pos_sel;
    logic [LEN_W-1:0]       idx1_full;
    logic [LEN_W-1:0]       idx1_sel;
    logic [LEN_W-1:0]       idx2_full;
    logic [LEN_W-1:0]       idx2_sel;
    cmd_t                   cmd;

    assign push      = a_valid_reg && cmd_ready;
    assign s_ready   = !a_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = a_valid_reg;

    // Write pointer wraps at the active length
    assign wp_plus = {1'b0, wp_reg} + LEN_W'(1);
    assign wp_next = (wp_plus >= line_len) ? '0 : wp_plus[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            wp_reg      <= '0;
        end else begin
            if (restart) begin
                wp_reg <= '0;
            end else if (accept) begin
                wp_reg <= wp_next;
            end
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (push) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // Delay times length, registered
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_prod_reg   <= {{LEN_W{1'b0}}, s_delay_fraction} *
                            {{FRAC_BITS{1'b0}}, line_len};
            a_sample_reg <= s_sample_in;
            a_wp_reg     <= wp_reg;
        end
    end

    // Read position, with the wrapped form computed alongside
    assign pos_direct  = $signed({1'b0, 1'b0, a_wp_reg, {FRAC_BITS{1'b0}}})
                       - $signed({1'b0, a_prod_reg});
    assign pos_wrapped = $signed({1'b0, ({1'b0, a_wp_reg} + line_len), {FRAC_BITS{1'b0}}})
                       - $signed({1'b0, a_prod_reg});
    assign pos_sel     = pos_direct[POS_W-1] ? pos_wrapped : pos_direct;

    // First and second ring index; the second wraps to zero
    assign idx1_full = pos_sel[FRAC_BITS +: LEN_W];
    assign idx1_sel  = (idx1_full >= line_len) ? '0 : idx1_full;
    assign idx2_full = idx1_sel + LEN_W'(1);
    assign idx2_sel  = (idx2_full >= line_len) ? '0 : idx2_full;

    always_comb begin
        cmd.sample  = a_sample_reg;
        cmd.wr_addr = a_wp_reg;
        cmd.idx1    = idx1_sel[ADDR_W-1:0];
        cmd.idx2    = idx2_sel[ADDR_W-1:0];
        cmd.frac    = pos_sel[FRAC_BITS-1:0];
    end

    assign cmd_data = cmd;

endmodule

`default_nettype wire

// ===== hw/rtl/ifdl_back.sv =====
// ----------------------------------------------------------------------------
// ifdl_back
// Owns the ring memory: reads both neighbors, stores the new sample and
// interpolates between them.
// ----------------------------------------------------------------------------
`default_nettype none

module ifdl_back #(
    parameter int DEPTH       = ifdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = ifdl_pkg::SAMPLE_BITS_DEF,
    localparam int ADDR_W     = $clog2(DEPTH),
    localparam int CMD_W      = SAMPLE_BITS + 3 * ADDR_W + ifdl_pkg::FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire logic [CMD_W-1:0]       cmd_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out
);
    import ifdl_pkg::*;

    localparam int LEN_W  = ADDR_W + 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int MUL_W  = DIFF_W + FRAC_BITS + 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [ADDR_W-1:0]      wr_addr;
        logic [ADDR_W-1:0]      idx1;
        logic [ADDR_W-1:0]      idx2;
        logic [FRAC_BITS-1:0]   frac;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_RD1 = 4'b0001,
        ST_RD2 = 4'b0010,
        ST_WR  = 4'b0100,
        ST_MUL = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   q_cmd;
    cmd_t                   cmd_reg;
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   hit_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [LEN_W-1:0]       fill_reg;
    logic [SAMPLE_BITS-1:0] val1_reg;
    logic [SAMPLE_BITS-1:0] val2;
    logic [DIFF_W-1:0]      diff_reg;
    logic signed [MUL_W-1:0] prod_full;
    logic [SAMPLE_BITS-1:0] prod_reg;
    logic [SAMPLE_BITS-1:0] fin_val1_reg;
    logic                   fin_valid_reg;
    logic                   fin_take;
    logic                   mul_load;
    logic                   pop;
    logic                   wr_en;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;

    assign q_cmd     = cmd_data;
    assign cmd_ready = (state_reg == ST_RD1);
    assign pop       = cmd_valid && cmd_ready;
    assign wr_en     = (state_reg == ST_WR);
    assign fin_take  = fin_valid_reg && (!m_valid_reg || m_ready);
    assign mul_load  = (state_reg == ST_MUL) && (!fin_valid_reg || fin_take);

    // Sequencer: read first, read second, write, multiply
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RD1: if (cmd_valid) state_next = ST_RD2;
            ST_RD2: state_next = ST_WR;
            ST_WR:  state_next = ST_MUL;
            ST_MUL: if (mul_load) state_next = ST_RD1;
            default: state_next = ST_RD1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RD1;
            fill_reg      <= '0;
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // entries written so far always form a prefix of the ring
            if (wr_en && ({1'b0, cmd_reg.wr_addr} == fill_reg)) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (mul_load) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_take) begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Ring memory, one read and one write port
    assign rd_addr = (state_reg == ST_RD1) ? q_cmd.idx1 : cmd_reg.idx2;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cmd_reg.wr_addr] <= cmd_reg.sample;
        end
        rd_data_reg <= mem[rd_addr];
        // entries beyond the fill level are not cleared; the fill check makes them read as zero
        hit_reg     <= ({1'b0, rd_addr} < fill_reg);
    end

    // Datapath
    assign val2      = hit_reg ? rd_data_reg : '0;
    assign prod_full = $signed(diff_reg) * $signed({1'b0, cmd_reg.frac});

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_RD2) begin
            val1_reg <= hit_reg ? rd_data_reg : '0;
        end
        if (wr_en) begin
            diff_reg <= {val2[SAMPLE_BITS-1], val2} - {val1_reg[SAMPLE_BITS-1], val1_reg};
        end
        // arithmetic shift by the fraction width, kept to sample width
        if (mul_load) begin
            prod_reg     <= prod_full[FRAC_BITS +: SAMPLE_BITS];
            fin_val1_reg <= val1_reg;
        end
        if (fin_take) begin
            m_sample_reg <= fin_val1_reg + prod_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/interpolated_fractional_delay_line.sv =====
// ----------------------------------------------------------------------------
// interpolated_fractional_delay_line
// Ring delay line with per-request fractional delay and linear interpolation.
//
//   Channel  Direction  Handshake        Payload
//   cfg      in         psel/penable     paddr, pwdata, prdata (line_length)
//   s        in         s_valid/s_ready  s_sample_in, s_delay_fraction
//   m        out        m_valid/m_ready  m_sample_out
//
// Sustained rate is set by the back sequencer, which shares the single ring
// read port between the two neighbor reads and takes a new request only after
// its read, read, write and multiply states. A request passes the front stage,
// queue, back, final stage and output register. Reset is synchronous; the ring
// reads as zero through a fill level, so no clearing pass is needed. The queue
// lets the front keep accepting while the back or the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolated_fractional_delay_line #(
    parameter int DEPTH       = ifdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = ifdl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ifdl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ifdl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ifdl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // requests
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]   s_sample_in,
    input  wire logic [ifdl_pkg::FRAC_BITS-1:0]  s_delay_fraction,
    // results
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out
);
    import ifdl_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int CMD_W  = SAMPLE_BITS + 3 * ADDR_W + FRAC_BITS;
    localparam int INF_W  = $clog2(MAX_INFLIGHT + 1);

    logic [LEN_W-1:0]        line_len_reg;
    logic [LEN_W-1:0]        line_len_next;
    logic [CFG_LEN_BITS-1:0] cfg_len;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    cfg_wr;
    logic                    q_in_valid;
    logic                    q_in_ready;
    logic [CMD_W-1:0]        q_in_data;
    logic                    q_out_valid;
    logic                    q_out_ready;
    logic [CMD_W-1:0]        q_out_data;
    logic [INF_W-1:0]        inflight_reg;
    logic                    s_fire;
    logic                    m_fire;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_LINE_LENGTH);
    assign cfg_len = pwdata[CFG_LEN_BITS-1:0];

    // zero or above depth selects full depth
    assign line_len_next = ((cfg_len == '0) || (32'(cfg_len) > 32'(DEPTH))) ?
                           LEN_W'(DEPTH) : LEN_W'(cfg_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= LEN_W'(DEPTH);
        end else if (cfg_wr) begin
            line_len_reg <= line_len_next;
        end
    end

    assign prdata = (reg_idx == REG_LINE_LENGTH) ? APB_DATA_W'(line_len_reg) : '0;

    // Front: pointer and index calculation
    ifdl_front #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .line_len         (line_len_reg),
        .restart          (cfg_wr),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_in      (s_sample_in),
        .s_delay_fraction (s_delay_fraction),
        .cmd_valid        (q_in_valid),
        .cmd_ready        (q_in_ready),
        .cmd_data         (q_in_data)
    );

    // Command queue
    ifdl_queue #(
        .WIDTH   (CMD_W),
        .DEPTH_Q (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    // Back: memory and interpolation
    ifdl_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_out_valid),
        .cmd_ready    (q_out_ready),
        .cmd_data     (q_out_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // Requests accepted but not yet delivered
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            case ({s_fire, m_fire})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // Checks
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_len_reg != '0) && (line_len_reg <= LEN_W'(DEPTH)))
        else $error("line length out of range");

    a_no_orphan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (inflight_reg != '0))
        else $error("result without an accepted request");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= INF_W'(MAX_INFLIGHT))
        else $error("more requests held than storage allows");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == INF_W'(MAX_INFLIGHT)) |-> !s_ready)
        else $error("request accepted with every stage occupied");

endmodule

`default_nettype wire
